>>> rtl/core/htsp_pkg.sv
`default_nettype none

package htsp_pkg;

	localparam int unsigned TIME_BITS = 32;

	localparam int unsigned IN_DATA_BITS  = 32;
	localparam int unsigned IN_USER_BITS  = 1;
	localparam int unsigned OUT_DATA_BITS = 56;
	localparam int unsigned OUT_USER_BITS = 2;
	localparam int unsigned CFG_IDX_BITS  = 8;
	localparam int unsigned CFG_DATA_BITS = 16;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CMD_TRIG_T = 8'hF3;
	localparam logic [7:0] CMD_TRIG_H = 8'hF5;

	localparam logic [14:0] T_SCALE  = 15'd17572;
	localparam logic [14:0] H_SCALE  = 15'd12500;
	localparam logic [15:0] T_OFFSET = 16'd4685;
	localparam logic [15:0] H_OFFSET = 16'd600;
	localparam logic [31:0] ROUND_HALF = 32'd32768;

	typedef enum logic [0:0] {
		OP_TICK  = 1'b0,
		OP_REPLY = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		REQ_NONE   = 2'd0,
		REQ_DETECT = 2'd1,
		REQ_WRITE  = 2'd2,
		REQ_READ   = 2'd3
	} req_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_ADDR    = 8'd0,
		REG_CHANNEL = 8'd1,
		REG_POLL    = 8'd2,
		REG_CONV    = 8'd3
	} reg_idx_t;

	typedef enum logic [8:0] {
		PH_DETECT     = 9'b000000001,
		PH_ACK_DETECT = 9'b000000010,
		PH_ACK_TWRITE = 9'b000000100,
		PH_CONV_T     = 9'b000001000,
		PH_ACK_TREAD  = 9'b000010000,
		PH_ACK_HWRITE = 9'b000100000,
		PH_CONV_H     = 9'b001000000,
		PH_ACK_HREAD  = 9'b010000000,
		PH_WAIT       = 9'b100000000
	} phase_t;

	function automatic logic [7:0] crc8(input logic [7:0] a, input logic [7:0] b);
		logic [15:0] bits;
		logic [7:0] c;
		bits = {a, b};
		c = 8'd0;
		for (int i = 15; i >= 0; i--) begin
			if (c[7] ^ bits[i]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/humidity_temp_sensor_poller.sv
// an accepted input word is registered in the input register, then in the result register
// throughput: one word per cycle while result words are taken, one input register and one result register
// the state update and the scaling multiply sit between the two registers
// arst_n clears control state, the cycle state and both valid flags to defaults; data registers have no reset
// a result word waiting on m_tready stalls the input register, so s_tready drops while it holds a word
`default_nettype none

module humidity_temp_sensor_poller (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// reply_ok, reply_msb, reply_lsb, reply_check, zero fill
	input  wire logic [htsp_pkg::IN_DATA_BITS-1:0]   s_tdata,
	// opcode
	input  wire logic [htsp_pkg::IN_USER_BITS-1:0]   s_tuser,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// request_address, request_channel, command_byte, temperature_centi,
	// humidity_centi, error_flag, ready_flag, zero fill
	output logic [htsp_pkg::OUT_DATA_BITS-1:0]       m_tdata,
	// request_kind
	output logic [htsp_pkg::OUT_USER_BITS-1:0]       m_tuser,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [htsp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [htsp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import htsp_pkg::*;

	logic        valid_s1;
	op_t         op_s1;
	logic        ok_s1;
	logic [7:0]  msb_s1;
	logic [7:0]  lsb_s1;
	logic        good_s1;

	logic [6:0]  addr_q;
	logic [1:0]  chan_q;
	logic [15:0] poll_q;
	logic [7:0]  conv_q;

	phase_t                phase_q;
	logic [TIME_BITS-1:0]  time_q;
	logic [TIME_BITS-1:0]  stamp_q;
	logic [TIME_BITS-1:0]  cycle_stamp_q;
	logic [14:0]           temp_q;
	logic [14:0]           hum_q;
	logic                  err_q;
	logic                  rdy_q;

	logic                  out_valid_q;
	req_t                  kind_q;
	logic [6:0]            out_addr_q;
	logic [1:0]            out_chan_q;
	logic [7:0]            out_cmd_q;
	logic [14:0]           out_temp_q;
	logic [14:0]           out_hum_q;
	logic                  out_err_q;
	logic                  out_rdy_q;

	logic                  advance;
	logic [TIME_BITS-1:0]  time_inc;
	logic [TIME_BITS-1:0]  span;
	logic                  conv_done;
	logic                  poll_done;
	logic [15:0]           raw;
	logic [31:0]           t_prod;
	logic [31:0]           h_prod;
	logic [15:0]           t_conv;
	logic [15:0]           h_conv;

	phase_t                phase_d;
	logic [TIME_BITS-1:0]  time_d;
	logic [TIME_BITS-1:0]  stamp_d;
	logic [TIME_BITS-1:0]  cycle_stamp_d;
	logic [14:0]           temp_d;
	logic [14:0]           hum_d;
	logic                  err_d;
	logic                  rdy_d;
	req_t                  kind_d;
	logic [7:0]            cmd_d;

	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= op_t'(s_tuser[0]);
			ok_s1   <= s_tdata[0];
			msb_s1  <= s_tdata[8:1];
			lsb_s1  <= s_tdata[16:9];
			good_s1 <= (s_tdata[24:17] == crc8(s_tdata[8:1], s_tdata[16:9]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= 7'd64;
			chan_q <= 2'd0;
			poll_q <= 16'd1000;
			conv_q <= 8'd100;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ADDR:    addr_q <= cfg_data[6:0];
				REG_CHANNEL: chan_q <= cfg_data[1:0];
				REG_POLL:    poll_q <= cfg_data;
				REG_CONV:    conv_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign time_inc  = time_q + TIME_BITS'(1);
	assign span      = time_inc - stamp_q;
	assign conv_done = span >= TIME_BITS'(conv_q);
	assign poll_done = span >= TIME_BITS'(poll_q);

	assign raw    = {msb_s1, lsb_s1};
	assign t_prod = 32'(T_SCALE) * 32'(raw) + ROUND_HALF;
	assign h_prod = 32'(H_SCALE) * 32'(raw) + ROUND_HALF;
	assign t_conv = t_prod[31:16] - T_OFFSET;
	assign h_conv = h_prod[31:16] - H_OFFSET;

	always_comb begin
		phase_d       = phase_q;
		time_d        = time_q;
		stamp_d       = stamp_q;
		cycle_stamp_d = cycle_stamp_q;
		temp_d        = temp_q;
		hum_d         = hum_q;
		err_d         = err_q;
		rdy_d         = rdy_q;
		kind_d        = REQ_NONE;
		cmd_d         = 8'd0;
		if (op_s1 == OP_TICK) begin
			time_d = time_inc;
			unique case (phase_q)
				PH_DETECT: begin
					cycle_stamp_d = time_inc;
					kind_d        = REQ_DETECT;
					phase_d       = PH_ACK_DETECT;
				end
				PH_CONV_T: begin
					if (conv_done) begin
						kind_d  = REQ_READ;
						phase_d = PH_ACK_TREAD;
					end
				end
				PH_CONV_H: begin
					if (conv_done) begin
						kind_d  = REQ_READ;
						phase_d = PH_ACK_HREAD;
					end
				end
				PH_WAIT: begin
					if (poll_done) begin
						phase_d = PH_DETECT;
					end
				end
				default: ;
			endcase
		end else if (!ok_s1) begin
			unique case (phase_q)
				PH_ACK_DETECT, PH_ACK_TWRITE, PH_ACK_TREAD, PH_ACK_HWRITE,
				PH_ACK_HREAD: begin
					err_d   = 1'b1;
					rdy_d   = 1'b0;
					stamp_d = time_q;
					phase_d = PH_WAIT;
				end
				default: ;
			endcase
		end else begin
			unique case (phase_q)
				PH_ACK_DETECT: begin
					kind_d  = REQ_WRITE;
					cmd_d   = CMD_TRIG_T;
					phase_d = PH_ACK_TWRITE;
				end
				PH_ACK_TWRITE: begin
					stamp_d = time_q;
					phase_d = PH_CONV_T;
				end
				PH_ACK_TREAD: begin
					if (good_s1) begin
						temp_d = t_conv[14:0];
					end
					kind_d  = REQ_WRITE;
					cmd_d   = CMD_TRIG_H;
					phase_d = PH_ACK_HWRITE;
				end
				PH_ACK_HWRITE: begin
					err_d   = 1'b0;
					stamp_d = time_q;
					phase_d = PH_CONV_H;
				end
				PH_ACK_HREAD: begin
					if (good_s1) begin
						hum_d = h_conv[14:0];
					end
					rdy_d   = 1'b1;
					stamp_d = cycle_stamp_q;
					phase_d = PH_WAIT;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_DETECT;
			time_q        <= '0;
			stamp_q       <= '0;
			cycle_stamp_q <= '0;
			temp_q        <= '0;
			hum_q         <= '0;
			err_q         <= 1'b0;
			rdy_q         <= 1'b0;
		end else if (advance) begin
			phase_q       <= phase_d;
			time_q        <= time_d;
			stamp_q       <= stamp_d;
			cycle_stamp_q <= cycle_stamp_d;
			temp_q        <= temp_d;
			hum_q         <= hum_d;
			err_q         <= err_d;
			rdy_q         <= rdy_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_q     <= kind_d;
			out_addr_q <= (kind_d != REQ_NONE) ? addr_q : 7'd0;
			out_chan_q <= (kind_d != REQ_NONE) ? chan_q : 2'd0;
			out_cmd_q  <= cmd_d;
			out_temp_q <= temp_d;
			out_hum_q  <= hum_d;
			out_err_q  <= err_d;
			out_rdy_q  <= rdy_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = {7'd0, out_rdy_q, out_err_q, out_hum_q, out_temp_q, out_cmd_q,
		out_chan_q, out_addr_q};

endmodule

`default_nettype wire

>>> sim/humidity_temp_sensor_poller_test.sv
`default_nettype none

module humidity_temp_sensor_poller_test;
	timeunit 1ns;
	timeprecision 1ps;

	import htsp_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam logic [7:0] REG_NONE_LOW  = 8'd4;
	localparam logic [7:0] REG_NONE_MID  = 8'd5;
	localparam logic [7:0] REG_NONE_HIGH = 8'hFF;

	typedef struct {
		req_t        kind;
		logic [6:0]  addr;
		logic [1:0]  chan;
		logic [7:0]  cmd;
		logic [14:0] temp;
		logic [14:0] hum;
		logic        err;
		logic        rdy;
	} poll_word_t;

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata = '0;
	logic [IN_USER_BITS-1:0]  s_tuser = '0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_tdata;
	logic [OUT_USER_BITS-1:0] m_tuser;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	// sensor view kept by the testbench
	phase_t      ph = PH_DETECT;
	logic [31:0] now_ms = '0;
	logic [31:0] stamp_ms = '0;
	logic [31:0] start_ms = '0;
	logic [14:0] temp_c = '0;
	logic [14:0] hum_c = '0;
	logic        err_f = 1'b0;
	logic        rdy_f = 1'b0;
	logic [6:0]  cf_addr = 7'd64;
	logic [1:0]  cf_chan = 2'd0;
	logic [15:0] cf_poll = 16'd1000;
	logic [7:0]  cf_conv = 8'd100;

	poll_word_t awaited_words[$];
	int         errors = 0;
	int         cycle_count = 0;
	bit         no_idle = 1'b0;

	humidity_temp_sensor_poller u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("humidity_temp_sensor_poller test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= no_idle || ($urandom_range(99) >= 31);
	end

	function automatic logic [7:0] crc_of(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] c;
		logic [7:0] data_byte;
		c = 8'd0;
		for (int k = 0; k < 2; k++) begin
			data_byte = (k == 0) ? a : b;
			c = c ^ data_byte;
			for (int n = 0; n < 8; n++) begin
				c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic bit awaiting_reply(input phase_t p);
		case (p)
			PH_ACK_DETECT, PH_ACK_TWRITE, PH_ACK_TREAD, PH_ACK_HWRITE, PH_ACK_HREAD:
				return 1'b1;
			default:
				return 1'b0;
		endcase
	endfunction

	function automatic poll_word_t step_sensor(input op_t op, input logic ok,
		input logic [7:0] msb, input logic [7:0] lsb, input logic [7:0] chk);
		poll_word_t w;
		logic [15:0] raw;
		logic        good;
		logic [31:0] span;
		logic [31:0] prod;
		w.kind = REQ_NONE;
		w.cmd = 8'h00;
		raw = {msb, lsb};
		good = (chk == crc_of(msb, lsb));
		if (op == OP_TICK) begin
			now_ms = now_ms + 32'd1;
			span = now_ms - stamp_ms;
			case (ph)
				PH_DETECT: begin
					start_ms = now_ms;
					w.kind = REQ_DETECT;
					ph = PH_ACK_DETECT;
				end
				PH_CONV_T, PH_CONV_H: begin
					if (span >= 32'(cf_conv)) begin
						w.kind = REQ_READ;
						ph = (ph == PH_CONV_T) ? PH_ACK_TREAD : PH_ACK_HREAD;
					end
				end
				PH_WAIT: begin
					if (span >= 32'(cf_poll)) begin
						ph = PH_DETECT;
					end
				end
				default: ;
			endcase
		end else if (awaiting_reply(ph) && !ok) begin
			// bus failure: hold off one poll period
			err_f = 1'b1;
			rdy_f = 1'b0;
			stamp_ms = now_ms;
			ph = PH_WAIT;
		end else begin
			case (ph)
				PH_ACK_DETECT: begin
					w.kind = REQ_WRITE;
					w.cmd = CMD_TRIG_T;
					ph = PH_ACK_TWRITE;
				end
				PH_ACK_TWRITE: begin
					stamp_ms = now_ms;
					ph = PH_CONV_T;
				end
				PH_ACK_TREAD: begin
					if (good) begin
						prod = 32'(T_SCALE) * 32'(raw) + ROUND_HALF;
						temp_c = 15'(prod[31:16]) - 15'(T_OFFSET);
					end
					w.kind = REQ_WRITE;
					w.cmd = CMD_TRIG_H;
					ph = PH_ACK_HWRITE;
				end
				PH_ACK_HWRITE: begin
					err_f = 1'b0;
					stamp_ms = now_ms;
					ph = PH_CONV_H;
				end
				PH_ACK_HREAD: begin
					if (good) begin
						prod = 32'(H_SCALE) * 32'(raw) + ROUND_HALF;
						hum_c = 15'(prod[31:16]) - 15'(H_OFFSET);
					end
					rdy_f = 1'b1;
					stamp_ms = start_ms;
					ph = PH_WAIT;
				end
				default: ;
			endcase
		end
		w.addr = (w.kind != REQ_NONE) ? cf_addr : 7'd0;
		w.chan = (w.kind != REQ_NONE) ? cf_chan : 2'd0;
		w.temp = temp_c;
		w.hum = hum_c;
		w.err = err_f;
		w.rdy = rdy_f;
		return w;
	endfunction

	always @(posedge clk) begin
		poll_word_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_words.size() == 0) begin
				$error("result word with nothing outstanding: kind %0d data %h",
					m_tuser, m_tdata);
				errors++;
			end else begin
				w = awaited_words.pop_front();
				if (m_tuser != w.kind) begin
					$error("request_kind: expected %0d, got %0d", w.kind, m_tuser);
					errors++;
				end
				if (m_tdata[6:0] != w.addr) begin
					$error("request_address: expected %0d, got %0d", w.addr, m_tdata[6:0]);
					errors++;
				end
				if (m_tdata[8:7] != w.chan) begin
					$error("request_channel: expected %0d, got %0d", w.chan, m_tdata[8:7]);
					errors++;
				end
				if (m_tdata[16:9] != w.cmd) begin
					$error("command_byte: expected %h, got %h", w.cmd, m_tdata[16:9]);
					errors++;
				end
				if (m_tdata[31:17] != w.temp) begin
					$error("temperature_centi: expected %0d, got %0d",
						$signed(w.temp), $signed(m_tdata[31:17]));
					errors++;
				end
				if (m_tdata[46:32] != w.hum) begin
					$error("humidity_centi: expected %0d, got %0d",
						$signed(w.hum), $signed(m_tdata[46:32]));
					errors++;
				end
				if (m_tdata[47] != w.err) begin
					$error("error_flag: expected %0d, got %0d", w.err, m_tdata[47]);
					errors++;
				end
				if (m_tdata[48] != w.rdy) begin
					$error("ready_flag: expected %0d, got %0d", w.rdy, m_tdata[48]);
					errors++;
				end
			end
		end
	end

	task automatic send_word(input op_t op, input logic ok, input logic [7:0] msb,
		input logic [7:0] lsb, input logic [7:0] chk);
		while (!no_idle && $urandom_range(99) < 31) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, chk, lsb, msb, ok};
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
		awaited_words.push_back(step_sensor(op, ok, msb, lsb, chk));
	endtask

	task automatic tick();
		send_word(OP_TICK, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic reply(input logic ok, input logic [15:0] raw, input logic good);
		logic [7:0] chk;
		chk = crc_of(raw[15:8], raw[7:0]);
		if (!good) begin
			chk = chk ^ 8'($urandom_range(255, 1));
		end
		send_word(OP_REPLY, ok, raw[15:8], raw[7:0], chk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (awaited_words.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ADDR:    cf_addr = data[6:0];
			REG_CHANNEL: cf_chan = data[1:0];
			REG_POLL:    cf_poll = data;
			REG_CONV:    cf_conv = data[7:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	// well-formed polling with noise: replies mostly when one is pending
	task automatic poll_sensor(input int count, input int fail_pct, input int bad_pct,
		input int stray_pct);
		int sent;
		sent = 0;
		while (sent < count) begin
			if (awaiting_reply(ph)) begin
				if ($urandom_range(99) < 90) begin
					reply($urandom_range(99) >= fail_pct, 16'($urandom),
						$urandom_range(99) >= bad_pct);
				end else begin
					tick();
				end
				sent++;
			end else if ($urandom_range(99) < stray_pct) begin
				reply(1'($urandom), 16'($urandom), 1'($urandom));
			end else begin
				tick();
				sent++;
			end
			if ($urandom_range(999) < 3) begin
				wait_drained();
			end
		end
	endtask

	task automatic test_reset_defaults();
		reply(1'b1, 16'h1234, 1'b1);
		tick();
		reply(1'b0, 16'h0000, 1'b1);
	endtask

	task automatic test_register_masks();
		write_reg(REG_ADDR, 16'hFFFF);
		write_reg(REG_CHANNEL, 16'hFFFF);
		write_reg(REG_POLL, 16'h0000);
		write_reg(REG_CONV, 16'h0000);
		write_reg(REG_NONE_LOW, 16'h0000);
		write_reg(REG_NONE_MID, 16'h0000);
		write_reg(REG_NONE_HIGH, 16'h00FF);
	endtask

	task automatic test_zero_periods();
		tick();
		tick();
		reply(1'b1, 16'hA5A5, 1'b1);
		reply(1'b1, 16'h5A5A, 1'b0);
		tick();
		reply(1'b1, 16'hFFFF, 1'b1);
		reply(1'b1, 16'h0F0F, 1'b1);
		tick();
		reply(1'b1, 16'h0000, 1'b1);
		reply(1'b1, 16'h8000, 1'b1);
		tick();
		tick();
		reply(1'b1, 16'h0000, 1'b1);
		reply(1'b1, 16'h0000, 1'b1);
		tick();
		reply(1'b1, 16'h0000, 1'b0);
		reply(1'b0, 16'hFFFF, 1'b1);
	endtask

	task automatic test_long_periods();
		write_reg(REG_ADDR, 16'h0000);
		write_reg(REG_CHANNEL, 16'h0000);
		write_reg(REG_POLL, 16'hFFFF);
		write_reg(REG_CONV, 16'h00FF);
		no_idle = 1'b1;
		poll_sensor(540, 0, 0, 0);
		no_idle = 1'b0;
	endtask

	task automatic test_random_polling();
		for (int r = 0; r < 6; r++) begin
			write_reg(REG_ADDR, 16'($urandom));
			write_reg(REG_CHANNEL, 16'($urandom));
			write_reg(REG_POLL, (r == 0) ? 16'd1 : 16'($urandom_range(24)));
			write_reg(REG_CONV, {8'($urandom), (r == 0) ? 8'd1 : 8'($urandom_range(6))});
			poll_sensor(110, 6, 20, 5);
		end
	endtask

	initial begin
		int guard;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_register_masks();
		test_zero_periods();
		test_long_periods();
		test_random_polling();
		s_tvalid <= 1'b0;
		guard = 0;
		while (awaited_words.size() != 0 && guard < 2000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		if (awaited_words.size() != 0) begin
			$error("%0d result words never arrived", awaited_words.size());
			errors++;
		end
		if (errors == 0) begin
			$display("humidity_temp_sensor_poller test passed");
		end else begin
			$display("humidity_temp_sensor_poller test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
